[sv/sem_pkg.sv]
// Shared types, constants and helper functions for the screw-axis exponential map.
`timescale 1ns / 1ps
`default_nettype none
package sem_pkg;

    localparam int CORDIC_STEPS = 24;

    localparam logic signed [27:0] CORDIC_K    = 28'sd10188014;
    localparam logic signed [27:0] PI_Q24      = 28'sd52707179;
    localparam logic signed [27:0] HALF_PI_Q24 = 28'sd26353589;
    localparam logic signed [27:0] ONE_Q24     = 28'sd16777216;

    typedef logic signed [15:0] s16_t;
    typedef logic signed [27:0] cq_t;

    typedef struct {
        s16_t                w    [3];
        logic signed [33:0]  w2   [3][3];
        logic signed [48:0]  thww [3][3];
        logic signed [24:0]  vh   [3];
        logic        [23:0]  vl   [3];
    } aux_t;

    function automatic cq_t atan_q24(input int i);
        cq_t a;
        case (i)
            0:       a = 28'sd13176795;
            1:       a = 28'sd7778716;
            2:       a = 28'sd4110060;
            3:       a = 28'sd2086331;
            4:       a = 28'sd1047214;
            5:       a = 28'sd524117;
            6:       a = 28'sd262123;
            7:       a = 28'sd131069;
            8:       a = 28'sd65536;
            9:       a = 28'sd32768;
            10:      a = 28'sd16384;
            11:      a = 28'sd8192;
            12:      a = 28'sd4096;
            13:      a = 28'sd2048;
            14:      a = 28'sd1024;
            15:      a = 28'sd512;
            16:      a = 28'sd256;
            17:      a = 28'sd128;
            18:      a = 28'sd64;
            19:      a = 28'sd32;
            20:      a = 28'sd16;
            21:      a = 28'sd8;
            22:      a = 28'sd4;
            23:      a = 28'sd2;
            default: a = 28'sd0;
        endcase
        return a;
    endfunction

    function automatic int nxt3(input int j);
        int n;
        case (j)
            0:       n = 1;
            1:       n = 2;
            default: n = 0;
        endcase
        return n;
    endfunction

    function automatic s16_t sat16(input logic signed [21:0] v);
        s16_t r;
        if (v > 22'sd32767)
            r = 16'sh7fff;
        else if (v < -22'sd32768)
            r = 16'sh8000;
        else
            r = v[15:0];
        return r;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [52:0] v);
        logic signed [31:0] r;
        if (v > 53'sd2147483647)
            r = 32'sh7fffffff;
        else if (v < -53'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage
`default_nettype wire

[sv/screw_axis_exponential_map.sv]
// Top level of the screw-axis exponential map pipeline.
//
//   channel | direction | handshake          | payload
//   input   | in        | in_valid/in_stall  | axis_x..z, point_x..z, joint_angle
//   output  | out       | out_valid/out_stall| rot_00..rot_22, trans_x..z
//
// One transfer per cycle sustained while out_stall is low; pipeline stages are 2 input, 24 CORDIC,
// 4 rotation and 6 translation, the CORDIC taking one iteration per stage.
// Reset clears only the stage valid bits.
// A stalled result holds the whole pipeline; in_stall rises in the same cycle.
`timescale 1ns / 1ps
`default_nettype none
module screw_axis_exponential_map
    import sem_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic signed [15:0] axis_x,
    input  wire logic signed [15:0] axis_y,
    input  wire logic signed [15:0] axis_z,
    input  wire logic signed [31:0] point_x,
    input  wire logic signed [31:0] point_y,
    input  wire logic signed [31:0] point_z,
    input  wire logic signed [15:0] joint_angle,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic signed [15:0]      rot_00,
    output logic signed [15:0]      rot_01,
    output logic signed [15:0]      rot_02,
    output logic signed [15:0]      rot_10,
    output logic signed [15:0]      rot_11,
    output logic signed [15:0]      rot_12,
    output logic signed [15:0]      rot_20,
    output logic signed [15:0]      rot_21,
    output logic signed [15:0]      rot_22,
    output logic signed [31:0]      trans_x,
    output logic signed [31:0]      trans_y,
    output logic signed [31:0]      trans_z
);

    logic               adv;
    logic               prep_valid;
    cq_t                prep_z;
    logic               prep_flip;
    aux_t               prep_aux;
    logic               cor_valid;
    cq_t                cor_x, cor_y;
    logic               cor_flip;
    aux_t               cor_aux;
    logic               rot_valid;
    s16_t               rot_m [3][3];
    logic signed [36:0] rot_a [3][3];
    aux_t               rot_aux;
    s16_t               fin_rot [3][3];
    logic signed [31:0] fin_t [3];

    assign adv      = !out_valid || !out_stall;
    assign in_stall = !adv;

    sem_prep u_prep (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (adv),
        .in_valid    (in_valid),
        .axis_x      (axis_x),
        .axis_y      (axis_y),
        .axis_z      (axis_z),
        .point_x     (point_x),
        .point_y     (point_y),
        .point_z     (point_z),
        .joint_angle (joint_angle),
        .out_valid   (prep_valid),
        .z_out       (prep_z),
        .flip_out    (prep_flip),
        .aux_out     (prep_aux)
    );

    sem_cordic u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (prep_valid),
        .z_in      (prep_z),
        .flip_in   (prep_flip),
        .aux_in    (prep_aux),
        .out_valid (cor_valid),
        .x_out     (cor_x),
        .y_out     (cor_y),
        .flip_out  (cor_flip),
        .aux_out   (cor_aux)
    );

    sem_rot u_rot (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (cor_valid),
        .x_in      (cor_x),
        .y_in      (cor_y),
        .flip_in   (cor_flip),
        .aux_in    (cor_aux),
        .out_valid (rot_valid),
        .rot_out   (rot_m),
        .a_out     (rot_a),
        .aux_out   (rot_aux)
    );

    sem_trans u_trans (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (rot_valid),
        .rot_in    (rot_m),
        .a_in      (rot_a),
        .aux_in    (rot_aux),
        .out_valid (out_valid),
        .rot_out   (fin_rot),
        .trans_out (fin_t)
    );

    assign rot_00  = fin_rot[0][0];
    assign rot_01  = fin_rot[0][1];
    assign rot_02  = fin_rot[0][2];
    assign rot_10  = fin_rot[1][0];
    assign rot_11  = fin_rot[1][1];
    assign rot_12  = fin_rot[1][2];
    assign rot_20  = fin_rot[2][0];
    assign rot_21  = fin_rot[2][1];
    assign rot_22  = fin_rot[2][2];
    assign trans_x = fin_t[0];
    assign trans_y = fin_t[1];
    assign trans_z = fin_t[2];

    a_stall_back : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |-> in_stall)
        else $error("output stall did not hold the input");

    a_empty_open : assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled with empty output stage");

    a_hold_result : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(trans_x) && $stable(rot_11))
        else $error("stalled result changed");

endmodule
`default_nettype wire

[sv/sem_prep.sv]
// Input stages: angle reduction, axis products, cross product and outer-product terms.
`timescale 1ns / 1ps
`default_nettype none
module sem_prep
    import sem_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               en,
    input  wire logic               in_valid,
    input  wire logic signed [15:0] axis_x,
    input  wire logic signed [15:0] axis_y,
    input  wire logic signed [15:0] axis_z,
    input  wire logic signed [31:0] point_x,
    input  wire logic signed [31:0] point_y,
    input  wire logic signed [31:0] point_z,
    input  wire logic signed [15:0] joint_angle,
    output logic                    out_valid,
    output cq_t                     z_out,
    output logic                    flip_out,
    output aux_t                    aux_out
);

    s16_t               w_in [3];
    logic signed [31:0] r_in [3];

    logic               a_valid_reg;
    s16_t               a_w_reg  [3];
    s16_t               a_th_reg;
    cq_t                a_z_reg, a_z_next;
    logic               a_flip_reg, a_flip_next;
    logic signed [31:0] a_ww_reg [3][3];
    logic signed [31:0] a_ww_next [3][3];
    logic signed [47:0] a_pp_reg [3];
    logic signed [47:0] a_pp_next [3];
    logic signed [47:0] a_pn_reg [3];
    logic signed [47:0] a_pn_next [3];
    cq_t                z_full;

    logic               b_valid_reg;
    cq_t                b_z_reg;
    logic               b_flip_reg;
    aux_t               b_aux_reg, b_aux_next;

    assign w_in[0] = axis_x;
    assign w_in[1] = axis_y;
    assign w_in[2] = axis_z;
    assign r_in[0] = point_x;
    assign r_in[1] = point_y;
    assign r_in[2] = point_z;

    always_comb
    begin
        z_full      = {joint_angle[15], joint_angle, 11'b0};
        a_z_next    = z_full;
        a_flip_next = 1'b0;
        if (z_full > HALF_PI_Q24)
        begin
            a_z_next    = z_full - PI_Q24;
            a_flip_next = 1'b1;
        end
        else if (z_full < -HALF_PI_Q24)
        begin
            a_z_next    = z_full + PI_Q24;
            a_flip_next = 1'b1;
        end
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                a_ww_next[i][j] = 32'(w_in[i]) * 32'(w_in[j]);
            end
            a_pp_next[i] = 48'(w_in[nxt3(nxt3(i))]) * 48'(r_in[nxt3(i)]);
            a_pn_next[i] = 48'(w_in[nxt3(i)]) * 48'(r_in[nxt3(nxt3(i))]);
        end
    end

    always_comb
    begin
        logic signed [33:0] n2;
        logic signed [48:0] thp;
        logic signed [48:0] v;
        n2 = 34'(a_ww_reg[0][0]) + 34'(a_ww_reg[1][1]) + 34'(a_ww_reg[2][2]);
        for (int i = 0; i < 3; i++)
        begin
            b_aux_next.w[i] = a_w_reg[i];
            for (int j = 0; j < 3; j++)
            begin
                b_aux_next.w2[i][j] = 34'(a_ww_reg[i][j]) - ((i == j) ? n2 : 34'sd0);
                thp = 49'(a_th_reg) * 49'(a_ww_reg[i][j]);
                b_aux_next.thww[i][j] = thp <<< 1;
            end
            v = 49'(a_pp_reg[i]) - 49'(a_pn_reg[i]);
            b_aux_next.vh[i] = v[48:24];
            b_aux_next.vl[i] = v[23:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_w_reg    <= w_in;
            a_th_reg   <= joint_angle;
            a_z_reg    <= a_z_next;
            a_flip_reg <= a_flip_next;
            a_ww_reg   <= a_ww_next;
            a_pp_reg   <= a_pp_next;
            a_pn_reg   <= a_pn_next;
            b_z_reg    <= a_z_reg;
            b_flip_reg <= a_flip_reg;
            b_aux_reg  <= b_aux_next;
        end
    end

    assign out_valid = b_valid_reg;
    assign z_out     = b_z_reg;
    assign flip_out  = b_flip_reg;
    assign aux_out   = b_aux_reg;

endmodule
`default_nettype wire

[sv/sem_cordic.sv]
// Rotation-mode CORDIC, one iteration per pipeline stage, with side data carried along.
`timescale 1ns / 1ps
`default_nettype none
module sem_cordic
    import sem_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic en,
    input  wire logic in_valid,
    input  wire cq_t  z_in,
    input  wire logic flip_in,
    input  var aux_t  aux_in,
    output logic      out_valid,
    output cq_t       x_out,
    output cq_t       y_out,
    output logic      flip_out,
    output aux_t      aux_out
);

    logic valid_reg [CORDIC_STEPS];
    cq_t  x_reg     [CORDIC_STEPS];
    cq_t  y_reg     [CORDIC_STEPS];
    cq_t  z_reg     [CORDIC_STEPS];
    logic flip_reg  [CORDIC_STEPS];
    aux_t aux_reg   [CORDIC_STEPS];

    for (genvar gi = 0; gi < CORDIC_STEPS; gi++)
    begin : g_step
        logic vi;
        cq_t  xi, yi, zi;
        logic fi;
        aux_t ai;
        cq_t  x_next, y_next, z_next;

        if (gi == 0)
        begin : g_first
            assign vi = in_valid;
            assign xi = CORDIC_K;
            assign yi = 28'sd0;
            assign zi = z_in;
            assign fi = flip_in;
            assign ai = aux_in;
        end
        else
        begin : g_rest
            assign vi = valid_reg[gi-1];
            assign xi = x_reg[gi-1];
            assign yi = y_reg[gi-1];
            assign zi = z_reg[gi-1];
            assign fi = flip_reg[gi-1];
            assign ai = aux_reg[gi-1];
        end

        always_comb
        begin
            if (zi >= 28'sd0)
            begin
                x_next = xi - (yi >>> gi);
                y_next = yi + (xi >>> gi);
                z_next = zi - atan_q24(gi);
            end
            else
            begin
                x_next = xi + (yi >>> gi);
                y_next = yi - (xi >>> gi);
                z_next = zi + atan_q24(gi);
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[gi] <= 1'b0;
            else if (en)
                valid_reg[gi] <= vi;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[gi]    <= x_next;
                y_reg[gi]    <= y_next;
                z_reg[gi]    <= z_next;
                flip_reg[gi] <= fi;
                aux_reg[gi]  <= ai;
            end
        end
    end

    assign out_valid = valid_reg[CORDIC_STEPS-1];
    assign x_out     = x_reg[CORDIC_STEPS-1];
    assign y_out     = y_reg[CORDIC_STEPS-1];
    assign flip_out  = flip_reg[CORDIC_STEPS-1];
    assign aux_out   = aux_reg[CORDIC_STEPS-1];

endmodule
`default_nettype wire

[sv/sem_rot.sv]
// Rodrigues rotation stages: quadrant fix, products, matrix sum, rounding and I - R.
`timescale 1ns / 1ps
`default_nettype none
module sem_rot
    import sem_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic en,
    input  wire logic in_valid,
    input  wire cq_t  x_in,
    input  wire cq_t  y_in,
    input  wire logic flip_in,
    input  var aux_t  aux_in,
    output logic      out_valid,
    output s16_t      rot_out [3][3],
    output logic signed [36:0] a_out [3][3],
    output aux_t      aux_out
);

    localparam logic signed [60:0] ONE_Q52 = 61'sd1 <<< 52;

    logic               p1_valid_reg;
    cq_t                p1_s_reg, p1_s_next;
    cq_t                p1_omc_reg, p1_omc_next;
    aux_t               p1_aux_reg;

    logic               p2_valid_reg;
    logic signed [43:0] p2_sw_reg [3];
    logic signed [43:0] p2_sw_next [3];
    logic signed [61:0] p2_ow_reg [3][3];
    logic signed [61:0] p2_ow_next [3][3];
    aux_t               p2_aux_reg;

    logic               p3_valid_reg;
    logic signed [59:0] p3_rf_reg [3][3];
    logic signed [59:0] p3_rf_next [3][3];
    aux_t               p3_aux_reg;

    logic               p4_valid_reg;
    s16_t               p4_rot_reg [3][3];
    s16_t               p4_rot_next [3][3];
    logic signed [36:0] p4_a_reg [3][3];
    logic signed [36:0] p4_a_next [3][3];
    aux_t               p4_aux_reg;

    always_comb
    begin
        cq_t c;
        c           = flip_in ? -x_in : x_in;
        p1_s_next   = flip_in ? -y_in : y_in;
        p1_omc_next = ONE_Q24 - c;
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            p2_sw_next[k] = 44'(p1_s_reg) * 44'(p1_aux_reg.w[k]);
            for (int j = 0; j < 3; j++)
            begin
                p2_ow_next[k][j] = 62'(p1_omc_reg) * 62'(p1_aux_reg.w2[k][j]);
            end
        end
    end

    always_comb
    begin
        logic signed [43:0] t [3][3];
        t[0][0] = 44'sd0;
        t[0][1] = -p2_sw_reg[2];
        t[0][2] = p2_sw_reg[1];
        t[1][0] = p2_sw_reg[2];
        t[1][1] = 44'sd0;
        t[1][2] = -p2_sw_reg[0];
        t[2][0] = -p2_sw_reg[1];
        t[2][1] = p2_sw_reg[0];
        t[2][2] = 44'sd0;
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                p3_rf_next[i][j] = ((i == j) ? ONE_Q52[59:0] : 60'sd0)
                                 + (60'(t[i][j]) <<< 14)
                                 + p2_ow_reg[i][j][59:0];
            end
        end
    end

    always_comb
    begin
        logic signed [60:0] r;
        logic signed [60:0] a;
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                r = 61'(p3_rf_reg[i][j]) + (61'sd1 <<< 37);
                p4_rot_next[i][j] = sat16(r[59:38]);
                a = ((i == j) ? ONE_Q52 : 61'sd0) - 61'(p3_rf_reg[i][j]) + (61'sd1 <<< 23);
                p4_a_next[i][j] = a[60:24];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            p3_valid_reg <= 1'b0;
            p4_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            p1_valid_reg <= in_valid;
            p2_valid_reg <= p1_valid_reg;
            p3_valid_reg <= p2_valid_reg;
            p4_valid_reg <= p3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_s_reg   <= p1_s_next;
            p1_omc_reg <= p1_omc_next;
            p1_aux_reg <= aux_in;
            p2_sw_reg  <= p2_sw_next;
            p2_ow_reg  <= p2_ow_next;
            p2_aux_reg <= p1_aux_reg;
            p3_rf_reg  <= p3_rf_next;
            p3_aux_reg <= p2_aux_reg;
            p4_rot_reg <= p4_rot_next;
            p4_a_reg   <= p4_a_next;
            p4_aux_reg <= p3_aux_reg;
        end
    end

    assign out_valid = p4_valid_reg;
    assign rot_out   = p4_rot_reg;
    assign a_out     = p4_a_reg;
    assign aux_out   = p4_aux_reg;

endmodule
`default_nettype wire

[sv/sem_trans.sv]
// Translation stages: M = (I - R) W + theta w w^T, then M v with rounding and saturation.
`timescale 1ns / 1ps
`default_nettype none
module sem_trans
    import sem_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic en,
    input  wire logic in_valid,
    input  var s16_t  rot_in [3][3],
    input  wire logic signed [36:0] a_in [3][3],
    input  var aux_t  aux_in,
    output logic      out_valid,
    output s16_t      rot_out [3][3],
    output logic signed [31:0] trans_out [3]
);

    logic               q1_valid_reg;
    logic signed [52:0] q1_pp_reg [3][3];
    logic signed [52:0] q1_pp_next [3][3];
    logic signed [52:0] q1_pn_reg [3][3];
    logic signed [52:0] q1_pn_next [3][3];
    s16_t               q1_rot_reg [3][3];
    aux_t               q1_aux_reg;

    logic               q2_valid_reg;
    logic signed [41:0] q2_m_reg [3][3];
    logic signed [41:0] q2_m_next [3][3];
    s16_t               q2_rot_reg [3][3];
    aux_t               q2_aux_reg;

    logic               q3_valid_reg;
    logic signed [66:0] q3_mh_reg [3][3];
    logic signed [66:0] q3_mh_next [3][3];
    logic signed [66:0] q3_ml_reg [3][3];
    logic signed [66:0] q3_ml_next [3][3];
    s16_t               q3_rot_reg [3][3];

    logic               q4_valid_reg;
    logic signed [68:0] q4_sh_reg [3];
    logic signed [68:0] q4_sh_next [3];
    logic signed [68:0] q4_sl_reg [3];
    logic signed [68:0] q4_sl_next [3];
    s16_t               q4_rot_reg [3][3];

    logic               q5_valid_reg;
    logic signed [52:0] q5_t_reg [3];
    logic signed [52:0] q5_t_next [3];
    s16_t               q5_rot_reg [3][3];

    logic               q6_valid_reg;
    logic signed [31:0] q6_t_reg [3];
    logic signed [31:0] q6_t_next [3];
    s16_t               q6_rot_reg [3][3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                q1_pp_next[i][j] = 53'(a_in[i][nxt3(j)]) * 53'(aux_in.w[nxt3(nxt3(j))]);
                q1_pn_next[i][j] = 53'(a_in[i][nxt3(nxt3(j))]) * 53'(aux_in.w[nxt3(j)]);
            end
        end
    end

    always_comb
    begin
        logic signed [55:0] acc;
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                acc = 56'(q1_aux_reg.thww[i][j]) + 56'(q1_pp_reg[i][j])
                    - 56'(q1_pn_reg[i][j]) + (56'sd1 <<< 13);
                q2_m_next[i][j] = acc[55:14];
            end
        end
    end

    always_comb
    begin
        logic signed [24:0] vl_s;
        for (int j = 0; j < 3; j++)
        begin
            vl_s = {1'b0, q2_aux_reg.vl[j]};
            for (int i = 0; i < 3; i++)
            begin
                q3_mh_next[i][j] = 67'(q2_m_reg[i][j]) * 67'(q2_aux_reg.vh[j]);
                q3_ml_next[i][j] = 67'(q2_m_reg[i][j]) * 67'(vl_s);
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            q4_sh_next[i] = 69'(q3_mh_reg[i][0]) + 69'(q3_mh_reg[i][1]) + 69'(q3_mh_reg[i][2]);
            q4_sl_next[i] = 69'(q3_ml_reg[i][0]) + 69'(q3_ml_reg[i][1]) + 69'(q3_ml_reg[i][2]);
        end
    end

    always_comb
    begin
        logic signed [94:0] total;
        for (int i = 0; i < 3; i++)
        begin
            total = (95'(q4_sh_reg[i]) <<< 24) + 95'(q4_sl_reg[i]) + (95'sd1 <<< 41);
            q5_t_next[i] = total[94:42];
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            q6_t_next[i] = sat32(q5_t_reg[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q1_valid_reg <= 1'b0;
            q2_valid_reg <= 1'b0;
            q3_valid_reg <= 1'b0;
            q4_valid_reg <= 1'b0;
            q5_valid_reg <= 1'b0;
            q6_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            q1_valid_reg <= in_valid;
            q2_valid_reg <= q1_valid_reg;
            q3_valid_reg <= q2_valid_reg;
            q4_valid_reg <= q3_valid_reg;
            q5_valid_reg <= q4_valid_reg;
            q6_valid_reg <= q5_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q1_pp_reg  <= q1_pp_next;
            q1_pn_reg  <= q1_pn_next;
            q1_rot_reg <= rot_in;
            q1_aux_reg <= aux_in;
            q2_m_reg   <= q2_m_next;
            q2_rot_reg <= q1_rot_reg;
            q2_aux_reg <= q1_aux_reg;
            q3_mh_reg  <= q3_mh_next;
            q3_ml_reg  <= q3_ml_next;
            q3_rot_reg <= q2_rot_reg;
            q4_sh_reg  <= q4_sh_next;
            q4_sl_reg  <= q4_sl_next;
            q4_rot_reg <= q3_rot_reg;
            q5_t_reg   <= q5_t_next;
            q5_rot_reg <= q4_rot_reg;
            q6_t_reg   <= q6_t_next;
            q6_rot_reg <= q5_rot_reg;
        end
    end

    assign out_valid = q6_valid_reg;
    assign rot_out   = q6_rot_reg;
    assign trans_out = q6_t_reg;

endmodule
`default_nettype wire
